// ===== rtl/asm_pkg.sv =====
// Shared types and constants for the array set membership block.
package asm_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int ELEMENT_WIDTH   = 16;
	localparam int FILL_WIDTH      = 7;

	typedef enum logic [1:0] {
		OP_QUERY  = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} state_t;

	typedef struct packed {
		op_t                      operation;
		logic [ELEMENT_WIDTH-1:0] element;
	} request_t;

	typedef struct packed {
		logic                  was_member;
		logic [FILL_WIDTH-1:0] fill_count;
		logic                  set_empty;
		logic                  set_full;
		logic                  overflow;
	} result_t;

	typedef struct packed {
		logic compare;
		logic insert;
		logic remove;
	} cell_cmd_t;

endpackage

// ===== rtl/asm_cell.sv =====
// One storage cell: holds a value, matches it against the key, writes on insert or delete.
module asm_cell import asm_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = 7,
	parameter int INDEX       = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_cmd_t              cmd,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [COUNT_WIDTH-1:0] count,
	input  logic [VALUE_WIDTH-1:0] last_value,
	output logic [VALUE_WIDTH:0]   tap
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   hit_q;
	logic                   occupied;
	logic                   is_last;
	logic                   hit;

	assign occupied = COUNT_WIDTH'(INDEX) < count;
	assign is_last  = COUNT_WIDTH'(INDEX + 1) == count;
	assign hit      = occupied && (value_q == key);
	assign tap      = {hit, value_q & {VALUE_WIDTH{is_last}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.compare) begin
			hit_q <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && (count == COUNT_WIDTH'(INDEX))) begin
			value_q <= key;
		end else if (cmd.remove && hit_q) begin
			value_q <= last_value;
		end
	end

endmodule

// ===== rtl/asm_tree.sv =====
// Registered OR reduction of the cell taps: membership flag and last stored value.
module asm_tree import asm_pkg::*; #(
	parameter int N     = CAPACITY_DEF,
	parameter int WIDTH = VALUE_WIDTH_DEF + 1
) (
	input  logic                    clk,
	input  logic [N-1:0][WIDTH-1:0] taps,
	output logic [WIDTH-1:0]        merged_q
);

	logic [WIDTH-1:0] merged;

	always_comb begin
		merged = '0;
		for (int i = 0; i < N; i++) begin
			merged = merged | taps[i];
		end
	end

	always_ff @(posedge clk) begin
		merged_q <= merged;
	end

endmodule

// ===== rtl/array_set_membership.sv =====
// Top level: set of distinct values held in a row of compare-and-store cells.
//
//  channel   ports                       direction  handshake
//  request   start, busy, request        in         taken when start & !busy
//  result    done, result                out        one cycle at done, no backpressure
//
// Busy spans a compare and an update state: all cells compare in parallel
// and the OR tree registers membership and the last stored value, then the
// cells write the append or the swap with the last entry and the count
// updates. The result shows in the cycle after the update, while the next
// request may already enter. Reset empties the set.
module array_set_membership import asm_pkg::*; #(
	parameter int CAPACITY    = CAPACITY_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
	localparam int TAP_WIDTH   = VALUE_WIDTH + 1;

	state_t                             state_q;
	state_t                             state_n;
	cell_cmd_t                          cmd;
	logic                               accept;
	op_t                                op_q;
	logic [VALUE_WIDTH-1:0]             key_q;
	logic [COUNT_WIDTH-1:0]             count_q;
	logic [COUNT_WIDTH-1:0]             count_n;
	logic [CAPACITY-1:0][TAP_WIDTH-1:0] taps;
	logic [TAP_WIDTH-1:0]               merged_q;
	logic                               member;
	logic [VALUE_WIDTH-1:0]             last_value;
	logic                               is_full;
	logic                               insert_new;
	logic                               insert_ok;
	logic                               remove_ok;
	logic                               refused;
	result_t                            result_q;
	logic                               done_q;

	assign accept     = start && !busy;
	assign member     = merged_q[VALUE_WIDTH];
	assign last_value = merged_q[VALUE_WIDTH-1:0];
	assign is_full    = count_q == COUNT_WIDTH'(CAPACITY);
	assign insert_new = (op_q == OP_INSERT) && !member;
	assign insert_ok  = insert_new && !is_full;
	assign refused    = insert_new && is_full;
	assign remove_ok  = (op_q == OP_DELETE) && member;

	always_comb begin
		case (state_q)
			ST_IDLE: state_n = accept ? ST_CMP : ST_IDLE;
			ST_CMP:  state_n = ST_UPD;
			ST_UPD:  state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b1;
		cmd.compare = 1'b0;
		cmd.insert  = 1'b0;
		cmd.remove  = 1'b0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_CMP:  cmd.compare = 1'b1;
			ST_UPD: begin
				cmd.insert = insert_ok;
				cmd.remove = remove_ok;
			end
			default: busy = 1'b1;
		endcase
	end

	always_comb begin
		if (op_q == OP_CLEAR) begin
			count_n = '0;
		end else if (insert_ok) begin
			count_n = count_q + COUNT_WIDTH'(1);
		end else if (remove_ok) begin
			count_n = count_q - COUNT_WIDTH'(1);
		end else begin
			count_n = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= state_q == ST_UPD;
			if (state_q == ST_UPD) begin
				count_q <= count_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= request.operation;
			key_q <= VALUE_WIDTH'(request.element);
		end
		if (state_q == ST_UPD) begin
			result_q.was_member <= member;
			result_q.fill_count <= FILL_WIDTH'(count_n);
			result_q.set_empty  <= count_n == '0;
			result_q.set_full   <= count_n == COUNT_WIDTH'(CAPACITY);
			result_q.overflow   <= refused;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		asm_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.COUNT_WIDTH (COUNT_WIDTH),
			.INDEX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (key_q),
			.count      (count_q),
			.last_value (last_value),
			.tap        (taps[i])
		);
	end

	asm_tree #(
		.N     (CAPACITY),
		.WIDTH (TAP_WIDTH)
	) u_tree (
		.clk      (clk),
		.taps     (taps),
		.merged_q (merged_q)
	);

	assign done   = done_q;
	assign result = result_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflow |-> result.set_full && !result.was_member)
		else $error("overflow without a full set");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy ##1 busy ##1 done)
		else $error("request did not finish in two cycles");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_WIDTH'(CAPACITY))
		else $error("fill count beyond capacity");

	a_member_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && member |-> count_q != '0)
		else $error("match found in an empty set");

endmodule

// ===== sim/tb_array_set_membership.sv =====
// Self-checking testbench for the array set membership block: directed, fill and random tests.
module tb_array_set_membership;
	import asm_pkg::*;

	localparam int SET_CAP   = CAPACITY_DEF;
	localparam int POOL_SIZE = 80;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	request_t request;
	logic     done;
	result_t  result;

	array_set_membership i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	logic [ELEMENT_WIDTH-1:0] set_values [SET_CAP];
	int                       set_count;
	result_t                  pending_results [$];
	logic [ELEMENT_WIDTH-1:0] pool [POOL_SIZE];

	bit gaps_on;
	int mismatches;
	int n_query, n_insert, n_delete, n_clear;
	int n_hits, n_overflow, n_full, n_results;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit holds_value(logic [ELEMENT_WIDTH-1:0] v);
		for (int i = 0; i < set_count; i++)
			if (set_values[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic result_t apply_set_request(request_t r);
		result_t res;
		int      slot;
		logic    ovf;
		slot = -1;
		ovf  = 1'b0;
		for (int i = 0; i < set_count; i++)
			if (slot < 0 && set_values[i] == r.element)
				slot = i;
		case (r.operation)
			OP_INSERT: begin
				if (slot < 0) begin
					if (set_count >= SET_CAP) begin
						ovf = 1'b1;
					end else begin
						set_values[set_count] = r.element;
						set_count++;
					end
				end
			end
			OP_DELETE: begin
				if (slot >= 0) begin
					set_values[slot] = set_values[set_count-1];
					set_count--;
				end
			end
			OP_CLEAR: begin
				set_count = 0;
			end
			default: ;
		endcase
		res.was_member = (slot >= 0);
		res.fill_count = set_count[FILL_WIDTH-1:0];
		res.set_empty  = (set_count == 0);
		res.set_full   = (set_count == SET_CAP);
		res.overflow   = ovf;
		return res;
	endfunction

	task automatic send_request(op_t op, logic [ELEMENT_WIDTH-1:0] elem);
		request_t r;
		result_t  want;
		int       gap;
		r.operation = op;
		r.element   = elem;
		if (gaps_on && $urandom_range(99) < 7) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		want = apply_set_request(r);
		pending_results.push_back(want);
		case (op)
			OP_QUERY:  n_query++;
			OP_INSERT: n_insert++;
			OP_DELETE: n_delete++;
			default:   n_clear++;
		endcase
		if (want.overflow)
			n_overflow++;
		if (want.set_full)
			n_full++;
	endtask

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && done) begin
			n_results++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", result);
			end else begin
				want = pending_results.pop_front();
				if (want.was_member)
					n_hits++;
				if (result.was_member !== want.was_member ||
				    result.fill_count !== want.fill_count ||
				    result.set_empty !== want.set_empty ||
				    result.set_full !== want.set_full ||
				    result.overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, result);
				end
			end
		end
	end

	task automatic test_directed();
		send_request(OP_QUERY, 16'h0000);
		send_request(OP_DELETE, 16'h8000);
		send_request(OP_INSERT, 16'h0000);
		send_request(OP_INSERT, 16'hFFFF);
		send_request(OP_INSERT, 16'hFFFF);
		send_request(OP_QUERY, 16'hFFFF);
		send_request(OP_QUERY, 16'h0001);
		send_request(OP_DELETE, 16'h5555);
		send_request(OP_DELETE, 16'h0000);
		send_request(OP_QUERY, 16'h0000);
		send_request(OP_QUERY, 16'hFFFF);
		send_request(OP_INSERT, 16'hAAAA);
		send_request(OP_INSERT, 16'h5555);
		send_request(OP_DELETE, 16'hFFFF);
		send_request(OP_QUERY, 16'h5555);
		send_request(OP_CLEAR, 16'hAAAA);
		send_request(OP_QUERY, 16'hAAAA);
		send_request(OP_CLEAR, 16'h1234);
		send_request(OP_INSERT, 16'h8000);
		send_request(OP_DELETE, 16'h8000);
		send_request(OP_DELETE, 16'h8000);
	endtask

	task automatic test_fill_and_overflow();
		logic [ELEMENT_WIDTH-1:0] v;
		repeat (2) begin
			while (set_count < SET_CAP)
				send_request(OP_INSERT, 16'($urandom_range(16'hFFFF)));
			repeat (4) begin
				do v = 16'($urandom_range(16'hFFFF)); while (holds_value(v));
				send_request(OP_INSERT, v);
			end
			send_request(OP_INSERT, set_values[SET_CAP-1]);
			send_request(OP_QUERY, set_values[7]);
			send_request(OP_DELETE, set_values[0]);
			send_request(OP_INSERT, v);
			send_request(OP_DELETE, set_values[SET_CAP-1]);
			send_request(OP_DELETE, set_values[5]);
			send_request(OP_QUERY, v);
			while (set_count < SET_CAP)
				send_request(OP_INSERT, 16'($urandom_range(16'hFFFF)));
			send_request(OP_CLEAR, set_values[3]);
		end
	endtask

	task automatic test_random_churn();
		int                       pick;
		logic [ELEMENT_WIDTH-1:0] v;
		for (int round = 0; round < 8; round++) begin
			gaps_on = (round != 4);
			foreach (pool[k])
				pool[k] = 16'($urandom_range(16'hFFFF));
			repeat (180) begin
				if ($urandom_range(9) == 0)
					v = 16'($urandom_range(16'hFFFF));
				else
					v = pool[$urandom_range(POOL_SIZE-1)];
				pick = $urandom_range(99);
				if (round % 2 == 0) begin
					if (pick < 60)
						send_request(OP_INSERT, v);
					else if (pick < 77)
						send_request(OP_QUERY, v);
					else
						send_request(OP_DELETE, v);
				end else begin
					if (pick < 2)
						send_request(OP_CLEAR, v);
					else if (pick < 55)
						send_request(OP_DELETE, v);
					else if (pick < 75)
						send_request(OP_INSERT, v);
					else
						send_request(OP_QUERY, v);
				end
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		int guard;
		arst_n     = 1'b0;
		start      = 1'b0;
		request    = '0;
		gaps_on    = 1'b1;
		set_count  = 0;
		mismatches = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_and_overflow();
		test_random_churn();

		@(negedge clk);
		start <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			mismatches++;
			$display("%0d results never arrived", pending_results.size());
		end

		$display("requests: %0d query, %0d insert, %0d delete, %0d clear; %0d results",
			n_query, n_insert, n_delete, n_clear, n_results);
		$display("member hits %0d, refused inserts %0d, results at full capacity %0d",
			n_hits, n_overflow, n_full);
		if (mismatches == 0) begin
			$display("tb_array_set_membership: done, clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("tb_array_set_membership: done, errors");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout");
		$display("tb_array_set_membership: done, errors");
		$finish;
	end

endmodule
